@@ sv/http_request_head_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// http request head parser assertion macros
// shared concurrent assertion forms, clocked on clk_i with reset gating
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_TOP_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_TOP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define HRHP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hrhp assertion failed");

// check on a registered result that is currently presented
`define HRHP_ASSERT_OUT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (out_valid_q && (cond)) |-> (prop)) else $error("hrhp result check failed");

`endif

@@ sv/hrhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg
// types, codes and constants of the http request head parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // widths of fields and registers
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MLimitW = 4;
  localparam int unsigned LimitW  = 11;
  localparam int unsigned KeyCntW = 3;

  // register reset values
  localparam logic [MLimitW-1:0] METHOD_LIMIT_RST = 4'd4;
  localparam logic [LimitW-1:0]  LIMIT_RST        = 11'd1024;

  // configuration register indexes
  localparam logic [1:0] CFG_METHOD_LIMIT = 2'd0;
  localparam logic [1:0] CFG_URL_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_HOST_LIMIT   = 2'd2;

  // field ids
  localparam logic [1:0] FID_NONE   = 2'd0;
  localparam logic [1:0] FID_METHOD = 2'd1;
  localparam logic [1:0] FID_URL    = 2'd2;
  localparam logic [1:0] FID_HOST   = 2'd3;

  // parse status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // characters
  localparam logic [ByteW-1:0] CH_SP    = 8'h20;
  localparam logic [ByteW-1:0] CH_COLON = 8'h3A;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;

  // full key length that can match
  localparam logic [KeyCntW-1:0] KEY_LEN = 3'd4;

  // parser phases
  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_LINE    = 3'd2,
    PH_LINE_CR = 3'd3,
    PH_KEY     = 3'd4,
    PH_SKIP    = 3'd5,
    PH_HOST    = 3'd6
  } phase_e;

  // characters of the expected header key
  function automatic logic [ByteW-1:0] host_char(input logic [1:0] idx);
    logic [ByteW-1:0] ch;
    unique case (idx)
      2'd0: ch = 8'h48;
      2'd1: ch = 8'h6F;
      2'd2: ch = 8'h73;
      2'd3: ch = 8'h74;
      default: ch = 8'h48;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/http_request_head_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_head_parser_top
// byte-wide parser of an http request head: method, url, host key and value
// ----------------------------------------------------------------------------
// Every accepted request (one byte or an end-of-input mark) gives exactly one
// result, in the cycle after acceptance. A request is taken in every cycle in
// which the result register is empty or its result is taken in that same
// cycle, so the parser sustains one byte per clock; the only limit is the
// single result register and the ready of the downstream side. Limits are
// written through the configuration channel, which is always ready; the user
// must write them only while no request is in flight: the block does not enforce it.
`include "http_request_head_parser_top_defines.svh"

module http_request_head_parser_top
  import hrhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic              end_of_input_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        field_id_o,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              byte_valid_o,
  output logic              field_end_o,
  output logic [1:0]        parse_status_o,
  // configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [LimitW-1:0] cfg_data_i
);

  // configuration registers
  logic [MLimitW-1:0] method_limit_q;
  logic [LimitW-1:0]  url_limit_q;
  logic [LimitW-1:0]  host_limit_q;

  // parser state
  phase_e             phase_q, phase_d;
  logic [LimitW-1:0]  field_count_q, field_count_d;
  logic [KeyCntW-1:0] key_count_q, key_count_d;
  logic               key_matches_q, key_matches_d;

  // result register
  logic               out_valid_q;
  logic [1:0]         field_id_q, field_id_d;
  logic [ByteW-1:0]   out_byte_q, out_byte_d;
  logic               byte_valid_q, byte_valid_d;
  logic               field_end_q, field_end_d;
  logic [1:0]         status_q, status_d;

  // field selection shared by the stored fields
  logic [ByteW-1:0]   term_char;
  logic [LimitW-1:0]  cur_limit;
  logic               is_term;
  logic               below_limit;
  logic               key_ok;
  logic               in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // terminator and limit of the current field
  always_comb begin
    term_char = CH_SP;
    cur_limit = url_limit_q;
    unique case (phase_q)
      PH_METHOD: cur_limit = LimitW'(method_limit_q);
      PH_HOST: begin
        term_char = CH_CR;
        cur_limit = host_limit_q;
      end
      default: cur_limit = url_limit_q;
    endcase
  end

  assign is_term     = (in_byte_i == term_char);
  assign below_limit = (field_count_q < cur_limit);
  assign key_ok      = (key_count_q == KEY_LEN) && key_matches_q;

  // result of the current request
  always_comb begin
    field_id_d   = FID_NONE;
    out_byte_d   = '0;
    byte_valid_d = 1'b0;
    field_end_d  = 1'b0;
    status_d     = ST_BUSY;
    if (end_of_input_i) begin
      status_d = ST_ERR;
    end else begin
      unique case (phase_q)
        PH_METHOD, PH_URL, PH_HOST: begin
          if (phase_q == PH_METHOD) begin
            field_id_d = FID_METHOD;
          end else if (phase_q == PH_URL) begin
            field_id_d = FID_URL;
          end else begin
            field_id_d = FID_HOST;
          end
          if (is_term) begin
            field_end_d = 1'b1;
            if (phase_q == PH_HOST) begin
              status_d = key_ok ? ST_OK : ST_ERR;
            end
          end else if (below_limit) begin
            out_byte_d   = in_byte_i;
            byte_valid_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // next parser state
  always_comb begin
    phase_d       = phase_q;
    field_count_d = field_count_q;
    key_count_d   = key_count_q;
    key_matches_d = key_matches_q;
    if (end_of_input_i) begin
      phase_d       = PH_METHOD;
      field_count_d = '0;
      key_count_d   = '0;
      key_matches_d = 1'b1;
    end else begin
      unique case (phase_q)
        PH_METHOD, PH_URL: begin
          if (is_term) begin
            field_count_d = '0;
            phase_d       = (phase_q == PH_METHOD) ? PH_URL : PH_LINE;
          end else if (below_limit) begin
            field_count_d = field_count_q + LimitW'(1);
          end
        end
        PH_LINE: begin
          if (in_byte_i == CH_CR) begin
            phase_d = PH_LINE_CR;
          end
        end
        PH_LINE_CR: begin
          if (in_byte_i == CH_LF) begin
            phase_d = PH_KEY;
          end else if (in_byte_i != CH_CR) begin
            phase_d = PH_LINE;
          end
        end
        PH_KEY: begin
          if (in_byte_i == CH_COLON) begin
            phase_d = PH_SKIP;
          end else if (key_count_q < KEY_LEN) begin
            if (in_byte_i != host_char(key_count_q[1:0])) begin
              key_matches_d = 1'b0;
            end
            key_count_d = key_count_q + KeyCntW'(1);
          end
        end
        PH_SKIP: begin
          phase_d       = PH_HOST;
          field_count_d = '0;
        end
        PH_HOST: begin
          if (is_term) begin
            phase_d       = PH_METHOD;
            field_count_d = '0;
            key_count_d   = '0;
            key_matches_d = 1'b1;
          end else if (below_limit) begin
            field_count_d = field_count_q + LimitW'(1);
          end
        end
        default: begin
          phase_d       = PH_METHOD;
          field_count_d = '0;
          key_count_d   = '0;
          key_matches_d = 1'b1;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_limit_q <= METHOD_LIMIT_RST;
      url_limit_q    <= LIMIT_RST;
      host_limit_q   <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_METHOD_LIMIT: method_limit_q <= cfg_data_i[MLimitW-1:0];
        CFG_URL_LIMIT:    url_limit_q    <= cfg_data_i;
        CFG_HOST_LIMIT:   host_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_METHOD;
      field_count_q <= '0;
      key_count_q   <= '0;
      key_matches_q <= 1'b1;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      field_count_q <= field_count_d;
      key_count_q   <= key_count_d;
      key_matches_q <= key_matches_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      field_id_q   <= field_id_d;
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      field_end_q  <= field_end_d;
      status_q     <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign field_id_o     = field_id_q;
  assign out_byte_o     = out_byte_q;
  assign byte_valid_o   = byte_valid_q;
  assign field_end_o    = field_end_q;
  assign parse_status_o = status_q;

  // checks
  `HRHP_ASSERT(a_key_count_range, key_count_q <= KEY_LEN)
  `HRHP_ASSERT(a_eoi_restarts,
    (in_fire && end_of_input_i) |=> (phase_q == PH_METHOD && key_count_q == '0))
  `HRHP_ASSERT_OUT(a_byte_has_field, byte_valid_q, field_id_q != FID_NONE && !field_end_q)
  `HRHP_ASSERT_OUT(a_ok_ends_host, status_q == ST_OK,
    field_end_q && field_id_q == FID_HOST)
  `HRHP_ASSERT_OUT(a_host_end_done, field_end_q && field_id_q == FID_HOST,
    status_q != ST_BUSY)

endmodule

@@ bench/tb_http_request_head_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_head_parser_top
// self-checking bench for the byte-wide http request head parser
// ----------------------------------------------------------------------------
// Bytes and end-of-input marks go in as requests on the input channel. A
// behavioral parser inside the bench tracks phase, kept byte count and key
// match, and queues the result that each accepted request must give. Results
// are compared field by field, in order. Directed heads cover dropped bytes,
// a bare CR, bad keys and the end-of-input mark. The limits are swept over
// their extremes, the output stalls long enough to fill the parser, and random
// well-formed heads mixed with broken ones and noise make up the bulk.
module tb_http_request_head_parser_top
  import hrhp_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT     = 32;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned FILL_BYTES   = 40;
  localparam logic [31:0] HOST_WORD    = "Host";

  // one result of the parser
  typedef struct packed {
    logic [1:0]       field_id;
    logic [ByteW-1:0] data;
    logic             kept;
    logic             field_end;
    logic [1:0]       status;
  } head_result_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [ByteW-1:0]  in_byte_i      = '0;
  logic              end_of_input_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [1:0]        field_id_o;
  logic [ByteW-1:0]  out_byte_o;
  logic              byte_valid_o;
  logic              field_end_o;
  logic [1:0]        parse_status_o;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i    = CFG_METHOD_LIMIT;
  logic [LimitW-1:0] cfg_data_i     = '0;

  // parser state as the bench sees it
  phase_e             parse_phase;
  logic [LimitW-1:0]  kept_count;
  logic [KeyCntW-1:0] key_seen;
  logic               key_is_host;
  logic [MLimitW-1:0] method_max;
  logic [LimitW-1:0]  url_max;
  logic [LimitW-1:0]  host_max;

  head_result_t expected_results[$];

  bit          quiet = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned heads_ok = 0;
  int unsigned heads_err = 0;

  http_request_head_parser_top dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_cnt, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // behavioral parser
  // ---------------------------------------------------------------------------

  function automatic void restart_parse();
    parse_phase = PH_METHOD;
    kept_count  = '0;
    key_seen    = '0;
    key_is_host = 1'b1;
  endfunction

  // terminator, kept byte or dropped byte of a stored field
  function automatic void field_step(input logic [ByteW-1:0] b, input logic [ByteW-1:0] term,
                                     input logic [LimitW-1:0] lim, input logic [1:0] fid,
                                     input phase_e nxt, inout head_result_t res);
    res.field_id = fid;
    if (b == term) begin
      res.field_end = 1'b1;
      kept_count    = '0;
      parse_phase   = nxt;
    end else if (kept_count < lim) begin
      res.data   = b;
      res.kept   = 1'b1;
      kept_count = kept_count + LimitW'(1);
    end
  endfunction

  function automatic head_result_t next_head_result(input logic [ByteW-1:0] b,
                                                    input logic eoi);
    head_result_t res;
    res          = '0;
    res.field_id = FID_NONE;
    res.status   = ST_BUSY;
    if (eoi) begin
      res.status = ST_ERR;
      restart_parse();
    end else begin
      case (parse_phase)
        PH_METHOD: field_step(b, CH_SP, LimitW'(method_max), FID_METHOD, PH_URL, res);
        PH_URL:    field_step(b, CH_SP, url_max, FID_URL, PH_LINE, res);
        PH_LINE: begin
          if (b == CH_CR) parse_phase = PH_LINE_CR;
        end
        // a CR without LF falls back to the line, another CR keeps waiting for LF
        PH_LINE_CR: begin
          if (b == CH_LF) parse_phase = PH_KEY;
          else if (b != CH_CR) parse_phase = PH_LINE;
        end
        // only the first four key bytes are compared
        PH_KEY: begin
          if (b == CH_COLON) begin
            parse_phase = PH_SKIP;
          end else if (key_seen < KEY_LEN) begin
            if (b != HOST_WORD[24 - 8 * key_seen[1:0] +: 8]) key_is_host = 1'b0;
            key_seen = key_seen + KeyCntW'(1);
          end
        end
        PH_SKIP: begin
          parse_phase = PH_HOST;
          kept_count  = '0;
        end
        PH_HOST: begin
          field_step(b, CH_CR, host_max, FID_HOST, PH_HOST, res);
          if (res.field_end) begin
            res.status = (key_seen == KEY_LEN && key_is_host) ? ST_OK : ST_ERR;
            restart_parse();
          end
        end
        default: restart_parse();
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // channels
  // ---------------------------------------------------------------------------

  // output ready: random stalls, a quiet mode, and long hold-offs on demand
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // result check, sampled mid-cycle where the handshake is stable
  always @(negedge clk_i) begin : result_check
    head_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display({"%0t: unexpected result, expected none, actual fid %0d byte %02h",
                  " kept %0b end %0b status %0d"},
                 $time, field_id_o, out_byte_o, byte_valid_o, field_end_o, parse_status_o);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        compare_field("field_id", want.field_id, field_id_o);
        compare_field("out_byte", want.data, out_byte_o);
        compare_field("byte_valid", want.kept, byte_valid_o);
        compare_field("field_end", want.field_end, field_end_o);
        compare_field("parse_status", want.status, parse_status_o);
        results_checked++;
      end
    end
  end

  // one request on the input channel, with random idle cycles in front
  task automatic send_item(input logic [ByteW-1:0] b, input logic eoi);
    logic taken;
    head_result_t res;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= b;
    end_of_input_i <= eoi;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    res = next_head_result(b, eoi);
    expected_results.push_back(res);
    items_sent++;
    if (res.status == ST_OK) heads_ok++;
    if (res.status == ST_ERR) heads_err++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [ByteW-1:0] random_byte_except(input logic [ByteW-1:0] avoid);
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(255)); while (b == avoid);
    return b;
  endfunction

  task automatic send_filler(input int n, input logic [ByteW-1:0] avoid);
    repeat (n) send_item(random_byte_except(avoid), 1'b0);
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [LimitW-1:0] value);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_METHOD_LIMIT) method_max = value[MLimitW-1:0];
    else if (idx == CFG_URL_LIMIT) url_max = value;
    else if (idx == CFG_HOST_LIMIT) host_max = value;
  endtask

  task automatic set_limits(input logic [MLimitW-1:0] m, input logic [LimitW-1:0] u,
                            input logic [LimitW-1:0] h);
    write_limit(CFG_METHOD_LIMIT, LimitW'(m));
    write_limit(CFG_URL_LIMIT, u);
    write_limit(CFG_HOST_LIMIT, h);
  endtask

  function automatic logic [LimitW-1:0] random_limit();
    case ($urandom_range(3))
      0:       return LimitW'($urandom_range(4));
      1:       return LimitW'($urandom_range(16, 5));
      2:       return '1;
      default: return LimitW'($urandom_range(2047));
    endcase
  endfunction

  // a request head with random content, sometimes cut short or corrupted
  task automatic send_random_request();
    logic [ByteW:0]   req[$];
    logic [ByteW-1:0] b;
    string            key;
    int               n;
    int               pos;
    // method and url
    repeat ($urandom_range(8)) req.push_back({1'b0, random_byte_except(CH_SP)});
    req.push_back({1'b0, CH_SP});
    repeat ($urandom_range(12)) req.push_back({1'b0, random_byte_except(CH_SP)});
    req.push_back({1'b0, CH_SP});
    // rest of the first line, with bare and doubled CRs now and then
    repeat ($urandom_range(6)) req.push_back({1'b0, random_byte_except(CH_CR)});
    case ($urandom_range(3))
      0: begin
        do b = ByteW'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
        req.push_back({1'b0, CH_CR});
        req.push_back({1'b0, b});
      end
      1: req.push_back({1'b0, CH_CR});
      default: ;
    endcase
    req.push_back({1'b0, CH_CR});
    req.push_back({1'b0, CH_LF});
    // header key
    case ($urandom_range(9))
      6:       key = "Hostname";
      7:       key = "Hos";
      8:       key = "hOST";
      9:       key = "";
      default: key = "Host";
    endcase
    for (int i = 0; i < key.len(); i++) req.push_back({1'b0, key[i]});
    if (key.len() == 0) begin
      repeat ($urandom_range(6)) req.push_back({1'b0, random_byte_except(CH_COLON)});
    end
    req.push_back({1'b0, CH_COLON});
    req.push_back({1'b0, ByteW'($urandom_range(255))});
    // host value
    repeat ($urandom_range(10)) req.push_back({1'b0, random_byte_except(CH_CR)});
    req.push_back({1'b0, CH_CR});
    // broken heads: end of input somewhere, or one byte replaced
    if ($urandom_range(99) < 15) begin
      pos      = $urandom_range(req.size() - 1);
      req[pos] = {1'b1, ByteW'($urandom_range(255))};
      while (req.size() > pos + 1) req.delete(req.size() - 1);
    end else if ($urandom_range(99) < 5) begin
      pos      = $urandom_range(req.size() - 1);
      req[pos] = {1'b0, ByteW'($urandom_range(255))};
    end
    n = req.size();
    for (int i = 0; i < n; i++) send_item(req[i][ByteW-1:0], req[i][ByteW]);
  endtask

  // raw bytes with occasional end marks, then an end mark to resync
  task automatic send_noise();
    repeat ($urandom_range(12, 1)) begin
      send_item(ByteW'($urandom_range(255)), ($urandom_range(7) == 0));
    end
    send_item(ByteW'($urandom_range(255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // full head at reset limits: dropped method byte, extreme bytes, bare CR
  task automatic test_reset_request();
    send_text("PUTXZ");
    send_item(CH_SP, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(CH_CR, 1'b0);
    send_text("x");
    send_item(CH_CR, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_text("Host:");
    send_item(CH_SP, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(CH_CR, 1'b0);
  endtask

  // key with a NUL byte, then a key that is too short
  task automatic test_key_mismatch();
    send_item(CH_SP, 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_text("Ho");
    send_item(8'h00, 1'b0);
    send_text("t:");
    send_item(CH_SP, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_text("Ho:x");
    send_item(CH_CR, 1'b0);
  endtask

  task automatic test_end_of_input();
    send_text("G");
    send_item(ByteW'($urandom_range(255)), 1'b1);
    send_item(8'hA5, 1'b1);
  endtask

  // all limits at zero, then at their maximum
  task automatic test_limit_extremes();
    wait_drained();
    set_limits('0, '0, '0);
    send_text("AB /x ");
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_text("Host: y");
    send_item(CH_CR, 1'b0);
    wait_drained();
    set_limits('1, '1, '1);
    send_filler(20, CH_SP);
    send_item(CH_SP, 1'b0);
    send_filler(FILL_BYTES, CH_SP);
    send_item(CH_SP, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_text("Host:");
    send_item(CH_SP, 1'b0);
    send_filler(FILL_BYTES, CH_CR);
    send_item(CH_CR, 1'b0);
    wait_drained();
    set_limits(METHOD_LIMIT_RST, LIMIT_RST, LIMIT_RST);
  endtask

  // output held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    quiet    <= 1'b1;
    hold_req <= hold_req + 1;
    send_random_request();
    send_random_request();
  endtask

  task automatic test_no_idle();
    quiet <= 1'b1;
    repeat (10) send_random_request();
    quiet <= 1'b0;
  endtask

  // random heads and noise, limits changed every few heads
  task automatic test_random_requests();
    int unsigned first;
    int unsigned heads;
    first = items_sent;
    heads = 0;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (heads % 6 == 5) begin
        wait_drained();
        set_limits(MLimitW'($urandom_range(15)), random_limit(), random_limit());
      end
      if ($urandom_range(9) == 0) send_noise();
      else send_random_request();
      heads++;
    end
  endtask

  initial begin
    method_max = METHOD_LIMIT_RST;
    url_max    = LIMIT_RST;
    host_max   = LIMIT_RST;
    restart_parse();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_request();
    test_key_mismatch();
    test_end_of_input();
    test_limit_extremes();
    test_backpressure();
    test_no_idle();
    test_random_requests();
    wait_drained();

    $display("ran %0d bytes and end marks, %0d results checked, %0d failures",
             items_sent, results_checked, fail_cnt);
    $display("heads accepted %0d, rejected %0d, limits swept 0 to max, output stalled %0d cycles",
             heads_ok, heads_err, HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
